/* hw/rtl/iso2j_pkg.sv */
// Shared types, byte constants and the single-byte code mapping for the ISO-2022-JP decoder.
package iso2j_pkg;

	localparam logic [7:0] BYTE_ESC    = 8'h1B;
	localparam logic [7:0] BYTE_SO     = 8'h0E;
	localparam logic [7:0] BYTE_SI     = 8'h0F;
	localparam logic [7:0] BYTE_SPACE  = 8'h20;
	localparam logic [7:0] BYTE_DEL    = 8'h7F;
	localparam logic [7:0] BYTE_TILDE  = 8'h7E;
	localparam logic [7:0] CH_LPAREN   = 8'h28;
	localparam logic [7:0] CH_DOLLAR   = 8'h24;
	localparam logic [7:0] KANA_FIRST  = 8'hA1;
	localparam logic [7:0] KANA_LAST   = 8'hDF;
	localparam logic [7:0] KANA7_LIMIT = 8'h60;
	localparam logic [15:0] KANA_OFFSET = 16'hFEC0;
	localparam logic [15:0] OVERLINE    = 16'h203E;

	// Result slots of one item, in the order they are delivered.
	localparam int SLOT_COUNT    = 7;
	localparam int SLOT_PRE_ESC  = 0;
	localparam int SLOT_PRE_B1   = 1;
	localparam int SLOT_PRE_PAR  = 2;
	localparam int SLOT_MAIN     = 3;
	localparam int SLOT_POST     = 4;
	localparam int SLOT_POST_B1  = 5;
	localparam int SLOT_POST_PAR = 6;

	typedef logic [SLOT_COUNT-1:0] iso2j_slots_t;

	// Work record that the front hands to the back for one item.
	typedef struct packed {
		iso2j_slots_t mask;
		logic [7:0]   esc_b1;
		logic [7:0]   main_hi;
		logic [7:0]   main_lo;
		logic         main_two;
		logic [7:0]   post_byte;
	} iso2j_rec_t;

	function automatic logic [15:0] single_code(input logic [7:0] b);
		logic [15:0] code;
		if (b >= KANA_FIRST && b <= KANA_LAST) begin
			code = {8'h00, b} + KANA_OFFSET;
		end else if (b == BYTE_TILDE) begin
			code = OVERLINE;
		end else begin
			code = {8'h00, b};
		end
		return code;
	endfunction

endpackage

/* hw/rtl/iso2j_front.sv */
// Front part: tracks mode, escape buffer and kanji lead byte, and builds one work record per item.
module iso2j_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_text,
	output logic                  rec_wr,
	output iso2j_pkg::iso2j_rec_t rec
);

	localparam logic [2:0] MODE_ASCII  = 3'd0;
	localparam logic [2:0] MODE_ROMAN  = 3'd1;
	localparam logic [2:0] MODE_KANJI  = 3'd2;
	localparam logic [2:0] MODE_KANA7  = 3'd3;
	localparam logic [2:0] MODE_KANA8  = 3'd4;
	localparam logic [2:0] MODE_BINARY = 3'd5;

	localparam logic [7:0] CH_AT = 8'h40;
	localparam logic [7:0] CH_B  = 8'h42;
	localparam logic [7:0] CH_D  = 8'h44;
	localparam logic [7:0] CH_H  = 8'h48;
	localparam logic [7:0] CH_I  = 8'h49;
	localparam logic [7:0] CH_J  = 8'h4A;
	localparam logic [7:0] CH_K  = 8'h4B;

	logic [2:0] mode_q;
	logic [1:0] esc_cnt_q;
	logic [7:0] esc_b1_q;
	logic [7:0] lead_q;
	logic       lead_vld_q;

	logic [2:0] n_mode;
	logic [1:0] n_cnt;
	logic [7:0] n_b1;
	logic [7:0] n_lead;
	logic       n_lv;
	logic       run_main;
	logic       accept;
	logic [7:0] b;

	assign accept = push && !full;
	assign b      = data_byte;

	always_comb begin
		n_mode   = mode_q;
		n_cnt    = esc_cnt_q;
		n_b1     = esc_b1_q;
		n_lead   = lead_q;
		n_lv     = lead_vld_q;
		run_main = 1'b0;
		rec      = '0;

		if (b != 8'h00) begin
			case (esc_cnt_q)
				2'd1: begin
					if (b == iso2j_pkg::CH_LPAREN || b == iso2j_pkg::CH_DOLLAR) begin
						n_cnt = 2'd2;
						n_b1  = b;
					end else if (b == CH_K) begin
						n_mode = MODE_KANJI;
						n_cnt  = 2'd0;
					end else if (b == CH_H) begin
						n_mode = MODE_ASCII;
						n_cnt  = 2'd0;
					end else begin
						rec.mask[iso2j_pkg::SLOT_PRE_ESC] = 1'b1;
						n_mode   = MODE_BINARY;
						n_cnt    = 2'd0;
						run_main = 1'b1;
					end
				end
				2'd2: begin
					if (esc_b1_q == iso2j_pkg::CH_LPAREN) begin
						if (b == CH_B) begin
							n_mode = MODE_ASCII;
							n_cnt  = 2'd0;
						end else if (b == CH_I) begin
							n_mode = MODE_KANA7;
							n_cnt  = 2'd0;
						end else if (b == CH_J) begin
							n_mode = MODE_ROMAN;
							n_cnt  = 2'd0;
						end else begin
							rec.mask[iso2j_pkg::SLOT_PRE_ESC] = 1'b1;
							rec.mask[iso2j_pkg::SLOT_PRE_B1]  = 1'b1;
							rec.esc_b1 = esc_b1_q;
							n_mode   = MODE_ASCII;
							n_cnt    = 2'd0;
							run_main = 1'b1;
						end
					end else if (b == CH_AT || b == CH_B) begin
						n_mode = MODE_KANJI;
						n_cnt  = 2'd0;
					end else if (b == iso2j_pkg::CH_LPAREN) begin
						n_cnt = 2'd3;
					end else begin
						rec.mask[iso2j_pkg::SLOT_PRE_ESC] = 1'b1;
						rec.mask[iso2j_pkg::SLOT_PRE_B1]  = 1'b1;
						rec.esc_b1 = esc_b1_q;
						n_mode   = MODE_BINARY;
						n_cnt    = 2'd0;
						run_main = 1'b1;
					end
				end
				2'd3: begin
					if (b == CH_AT || b == CH_B || b == CH_D) begin
						n_mode = MODE_KANJI;
						n_cnt  = 2'd0;
					end else begin
						rec.mask[iso2j_pkg::SLOT_PRE_ESC] = 1'b1;
						rec.mask[iso2j_pkg::SLOT_PRE_B1]  = 1'b1;
						rec.mask[iso2j_pkg::SLOT_PRE_PAR] = 1'b1;
						rec.esc_b1 = esc_b1_q;
						n_mode   = MODE_BINARY;
						n_cnt    = 2'd0;
						run_main = 1'b1;
					end
				end
				default: begin
					run_main = 1'b1;
				end
			endcase
		end

		// A failed escape leaves the current byte to be decoded in the new mode.
		if (run_main) begin
			if (lead_vld_q) begin
				n_lv = 1'b0;
				rec.mask[iso2j_pkg::SLOT_MAIN] = 1'b1;
				rec.main_two = 1'b1;
				rec.main_hi  = lead_q;
				rec.main_lo  = b;
			end else if (b == iso2j_pkg::BYTE_ESC) begin
				n_cnt = 2'd1;
			end else if (b == iso2j_pkg::BYTE_SO) begin
				n_mode = MODE_KANA8;
			end else if (b == iso2j_pkg::BYTE_SI) begin
				n_mode = MODE_ASCII;
			end else if (b < iso2j_pkg::BYTE_SPACE) begin
				n_mode = MODE_BINARY;
				rec.mask[iso2j_pkg::SLOT_MAIN] = 1'b1;
				rec.main_lo = b;
			end else if (b < iso2j_pkg::KANA7_LIMIT && n_mode == MODE_KANA7) begin
				rec.mask[iso2j_pkg::SLOT_MAIN] = 1'b1;
				rec.main_lo = {1'b1, b[6:0]};
			end else if (b == iso2j_pkg::BYTE_DEL) begin
				n_mode = MODE_BINARY;
				rec.mask[iso2j_pkg::SLOT_MAIN] = 1'b1;
				rec.main_lo = b;
			end else if (b < iso2j_pkg::BYTE_DEL) begin
				if (n_mode == MODE_KANJI) begin
					n_lead = b;
					n_lv   = 1'b1;
				end else begin
					rec.mask[iso2j_pkg::SLOT_MAIN] = 1'b1;
					rec.main_lo = b;
				end
			end else if (b >= iso2j_pkg::KANA_FIRST && b <= iso2j_pkg::KANA_LAST &&
					n_mode == MODE_KANA8) begin
				rec.mask[iso2j_pkg::SLOT_MAIN] = 1'b1;
				rec.main_lo = b;
			end else begin
				n_mode = MODE_BINARY;
				rec.mask[iso2j_pkg::SLOT_MAIN] = 1'b1;
				rec.main_lo = b;
			end
		end

		// End of text flushes a pending escape or lead byte and starts over in ascii.
		if (end_of_text) begin
			case (n_cnt)
				2'd1: begin
					rec.mask[iso2j_pkg::SLOT_POST] = 1'b1;
					rec.post_byte = iso2j_pkg::BYTE_ESC;
				end
				2'd2: begin
					rec.mask[iso2j_pkg::SLOT_POST]    = 1'b1;
					rec.mask[iso2j_pkg::SLOT_POST_B1] = 1'b1;
					rec.post_byte = iso2j_pkg::BYTE_ESC;
					rec.esc_b1    = n_b1;
				end
				2'd3: begin
					rec.mask[iso2j_pkg::SLOT_POST]     = 1'b1;
					rec.mask[iso2j_pkg::SLOT_POST_B1]  = 1'b1;
					rec.mask[iso2j_pkg::SLOT_POST_PAR] = 1'b1;
					rec.post_byte = iso2j_pkg::BYTE_ESC;
					rec.esc_b1    = n_b1;
				end
				default: begin
					if (n_lv) begin
						rec.mask[iso2j_pkg::SLOT_POST] = 1'b1;
						rec.post_byte = n_lead;
					end
				end
			endcase
			n_mode = MODE_ASCII;
			n_cnt  = 2'd0;
			n_lv   = 1'b0;
			n_lead = 8'h00;
		end
	end

	// Items that produce nothing never enter the queue.
	assign rec_wr = accept && (rec.mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_ASCII;
			esc_cnt_q  <= 2'd0;
			esc_b1_q   <= 8'h00;
			lead_q     <= 8'h00;
			lead_vld_q <= 1'b0;
		end else if (accept) begin
			mode_q     <= n_mode;
			esc_cnt_q  <= n_cnt;
			esc_b1_q   <= n_b1;
			lead_q     <= n_lead;
			lead_vld_q <= n_lv;
		end
	end

	a_lead_no_escape: assert property (@(posedge clk) disable iff (!arst_n)
		lead_vld_q |-> (esc_cnt_q == 2'd0))
		else $error("kanji lead byte held while an escape is pending");

	a_three_byte_escape: assert property (@(posedge clk) disable iff (!arst_n)
		(esc_cnt_q == 2'd3) |-> (esc_b1_q == iso2j_pkg::CH_DOLLAR))
		else $error("three-byte escape pending without a dollar sign");

endmodule

/* hw/rtl/iso2j_fifo.sv */
// Short queue of work records between the front and the back.
module iso2j_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  iso2j_pkg::iso2j_rec_t wr_data,
	output logic                  full,
	input  logic                  rd_en,
	output iso2j_pkg::iso2j_rec_t rd_data,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	iso2j_pkg::iso2j_rec_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("record queue count beyond depth");

	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && empty))
		else $error("record queue read while empty");

endmodule

/* hw/rtl/iso2j_back.sv */
// Back part: walks the slots of the head record and delivers one result per cycle while pop keeps the output free.
module iso2j_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  iso2j_pkg::iso2j_rec_t rec,
	input  logic                  rec_empty,
	output logic                  rec_rd,
	output logic [15:0]           char_code,
	output logic                  two_byte,
	output logic                  run_last,
	output logic                  empty,
	input  logic                  pop
);

	iso2j_pkg::iso2j_slots_t done_q;
	iso2j_pkg::iso2j_slots_t remaining;
	iso2j_pkg::iso2j_slots_t sel_oh;
	iso2j_pkg::iso2j_slots_t others;
	logic                    out_vld_q;
	logic [15:0]             code_q;
	logic                    two_q;
	logic                    last_q;
	logic                    can_load;
	logic                    load;
	logic [15:0]             sel_code;
	logic                    sel_two;

	assign remaining = rec_empty ? '0 : (rec.mask & ~done_q);
	assign sel_oh    = remaining & (~remaining + 1'b1);
	assign others    = remaining & ~sel_oh;
	assign can_load  = !out_vld_q || pop;
	assign load      = (remaining != '0) && can_load;
	// A record leaves when its last slot goes out; an empty mask is dropped at once.
	assign rec_rd    = !rec_empty && ((remaining == '0) || (load && (others == '0)));

	always_comb begin
		sel_two = 1'b0;
		if (sel_oh[iso2j_pkg::SLOT_PRE_ESC] || sel_oh[iso2j_pkg::SLOT_POST] &&
				rec.post_byte == iso2j_pkg::BYTE_ESC) begin
			sel_code = {8'h00, iso2j_pkg::BYTE_ESC};
		end else if (sel_oh[iso2j_pkg::SLOT_PRE_B1] || sel_oh[iso2j_pkg::SLOT_POST_B1]) begin
			sel_code = iso2j_pkg::single_code(rec.esc_b1);
		end else if (sel_oh[iso2j_pkg::SLOT_PRE_PAR] || sel_oh[iso2j_pkg::SLOT_POST_PAR]) begin
			sel_code = {8'h00, iso2j_pkg::CH_LPAREN};
		end else if (sel_oh[iso2j_pkg::SLOT_MAIN]) begin
			sel_two  = rec.main_two;
			sel_code = rec.main_two ? {rec.main_hi, rec.main_lo}
			                        : iso2j_pkg::single_code(rec.main_lo);
		end else begin
			sel_code = iso2j_pkg::single_code(rec.post_byte);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			done_q    <= '0;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
			if (rec_rd) begin
				done_q <= '0;
			end else if (load) begin
				done_q <= done_q | sel_oh;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= sel_code;
			two_q  <= sel_two;
			last_q <= (others == '0);
		end
	end

	assign empty     = !out_vld_q;
	assign char_code = code_q;
	assign two_byte  = two_q;
	assign run_last  = last_q;

	a_done_subset: assert property (@(posedge clk) disable iff (!arst_n)
		!rec_empty |-> ((done_q & ~rec.mask) == '0))
		else $error("slot marked done that the head record does not have");

	a_done_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rec_empty |-> (done_q == '0))
		else $error("slot progress left over with no record waiting");

endmodule

/* hw/rtl/iso2j_escape_top.sv */
// Top level of the ISO-2022-JP escape decoder: front, record queue and back.
// The decoder takes one text byte per cycle. A byte is accepted when push is high and full is
// low; the front updates mode, escape and lead-byte state in that same cycle and writes a work
// record into a queue of QUEUE_DEPTH entries. While pop keeps the output register free, the
// back delivers one result per cycle from the head record into that register, so a byte that
// yields more than one result (up to four, after a failed escape or at end of text) holds the
// back until all are out, while bytes that yield one or no result pass at one per cycle. The
// first result of a byte goes through the queue and then the output register to the outputs.
// Input stalls only when the queue fills behind a multi-result byte or a stalled pop.
// No clearing pass is needed after reset.
module iso2022jp_escape_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_text,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] char_code,
	output logic        two_byte,
	output logic        run_last
);

	iso2j_pkg::iso2j_rec_t wr_rec;
	iso2j_pkg::iso2j_rec_t rd_rec;
	logic                  rec_wr;
	logic                  rec_rd;
	logic                  rec_empty;

	iso2j_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.end_of_text (end_of_text),
		.rec_wr      (rec_wr),
		.rec         (wr_rec)
	);

	iso2j_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_wr),
		.wr_data (wr_rec),
		.full    (full),
		.rd_en   (rec_rd),
		.rd_data (rd_rec),
		.empty   (rec_empty)
	);

	iso2j_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec       (rd_rec),
		.rec_empty (rec_empty),
		.rec_rd    (rec_rd),
		.char_code (char_code),
		.two_byte  (two_byte),
		.run_last  (run_last),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

/* tb/iso2022jp_escape_decoder_tb.sv */
// Self-checking testbench for the ISO-2022-JP escape decoder with its own decoding predictor.
module iso2022jp_escape_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_J     = 8'h4A;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] HIGH_BIT = 8'h80;
	localparam logic [7:0] NO_BYTE  = 8'h00;

	localparam int MAX_CHARS     = 4;
	localparam int ITEM_TARGET   = 460;
	localparam int STALL_LIMIT   = 400;
	localparam int DRAIN_CYCLES  = 12;
	localparam int REPORT_LIMIT  = 10;
	localparam int DIRECTED_ROWS = 25;

	typedef enum logic [2:0] {
		MODE_ASCII, MODE_ROMAN, MODE_KANJI, MODE_KANA7, MODE_KANA8, MODE_BINARY
	} text_mode_t;

	typedef struct {
		logic [15:0] code;
		logic        two;
		logic        last;
	} char_result_t;

	typedef struct packed {
		logic [7:0]  b;
		logic        eot;
		logic        typed;
		logic [15:0] code;
	} text_row_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        end_of_text;
	logic        empty;
	logic        pop;
	logic [15:0] char_code;
	logic        two_byte;
	logic        run_last;

	// Rows with typed set carry the one code that the item must produce.
	text_row_t directed_rows [DIRECTED_ROWS] = '{
		{8'h41,                  1'b0, 1'b1, 16'h0041},
		{iso2j_pkg::BYTE_TILDE,  1'b0, 1'b1, 16'h203E},
		{iso2j_pkg::BYTE_ESC,    1'b0, 1'b0, 16'h0000},
		{iso2j_pkg::CH_LPAREN,   1'b0, 1'b0, 16'h0000},
		{CH_I,                   1'b0, 1'b0, 16'h0000},
		{8'h5F,                  1'b0, 1'b0, 16'h0000},
		{iso2j_pkg::BYTE_SO,     1'b0, 1'b0, 16'h0000},
		{iso2j_pkg::KANA_LAST,   1'b0, 1'b1, 16'hFF9F},
		{8'hA0,                  1'b0, 1'b0, 16'h0000},
		{iso2j_pkg::BYTE_SI,     1'b0, 1'b0, 16'h0000},
		{iso2j_pkg::BYTE_ESC,    1'b0, 1'b0, 16'h0000},
		{iso2j_pkg::CH_DOLLAR,   1'b0, 1'b0, 16'h0000},
		{CH_B,                   1'b0, 1'b0, 16'h0000},
		{iso2j_pkg::BYTE_TILDE,  1'b0, 1'b0, 16'h0000},
		{8'hFF,                  1'b0, 1'b0, 16'h0000},
		{8'h21,                  1'b1, 1'b0, 16'h0000},
		{iso2j_pkg::BYTE_ESC,    1'b0, 1'b0, 16'h0000},
		{iso2j_pkg::CH_DOLLAR,   1'b0, 1'b0, 16'h0000},
		{iso2j_pkg::CH_LPAREN,   1'b0, 1'b0, 16'h0000},
		{8'h5A,                  1'b0, 1'b0, 16'h0000},
		{iso2j_pkg::BYTE_ESC,    1'b0, 1'b0, 16'h0000},
		{iso2j_pkg::CH_LPAREN,   1'b1, 1'b0, 16'h0000},
		{iso2j_pkg::BYTE_ESC,    1'b0, 1'b0, 16'h0000},
		{CH_K,                   1'b0, 1'b0, 16'h0000},
		{8'h01,                  1'b1, 1'b1, 16'h0001}
	};

	text_mode_t   mode_q;
	logic [7:0]   esc_bytes [3];
	int           esc_len;
	logic [7:0]   lead_q;
	logic         lead_held;
	char_result_t step_chars [$];
	char_result_t awaited_chars [$];

	logic        row_typed;
	logic [15:0] row_code;
	int          max_gap = 5;
	int          max_stall = 5;
	int          items_sent;
	int          mismatches;
	int          idle_cycles;

	iso2022jp_escape_decoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.end_of_text(end_of_text),
		.empty      (empty),
		.pop        (pop),
		.char_code  (char_code),
		.two_byte   (two_byte),
		.run_last   (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [15:0] halfwidth_map(input logic [7:0] b);
		if (b >= iso2j_pkg::KANA_FIRST && b <= iso2j_pkg::KANA_LAST) begin
			return 16'hFF9F - {8'h00, iso2j_pkg::KANA_LAST - b};
		end
		if (b == iso2j_pkg::BYTE_TILDE) begin
			return iso2j_pkg::OVERLINE;
		end
		return {8'h00, b};
	endfunction

	function automatic void emit_char(input logic [15:0] code, input logic two);
		if (step_chars.size() < MAX_CHARS) begin
			step_chars.push_back('{code, two, 1'b0});
		end
	endfunction

	// A failed escape gives back ESC and the bytes held after it, then switches mode.
	function automatic void abort_escape(input text_mode_t next_mode);
		int held;
		held = esc_len;
		esc_len = 0;
		mode_q = next_mode;
		emit_char({8'h00, iso2j_pkg::BYTE_ESC}, 1'b0);
		for (int k = 1; k < held; k++) begin
			emit_char(halfwidth_map(esc_bytes[k]), 1'b0);
		end
	endfunction

	function automatic void decode_text_byte(input logic [7:0] b);
		case (esc_len)
			1: begin
				if (b == iso2j_pkg::CH_LPAREN || b == iso2j_pkg::CH_DOLLAR) begin
					esc_bytes[1] = b;
					esc_len = 2;
					return;
				end else if (b == CH_K) begin
					mode_q = MODE_KANJI;
					esc_len = 0;
					return;
				end else if (b == CH_H) begin
					mode_q = MODE_ASCII;
					esc_len = 0;
					return;
				end
				abort_escape(MODE_BINARY);
			end
			2: begin
				if (esc_bytes[1] == iso2j_pkg::CH_LPAREN) begin
					if (b == CH_B || b == CH_I || b == CH_J) begin
						mode_q = (b == CH_B) ? MODE_ASCII : (b == CH_I) ? MODE_KANA7 : MODE_ROMAN;
						esc_len = 0;
						return;
					end
					abort_escape(MODE_ASCII);
				end else if (b == CH_AT || b == CH_B) begin
					mode_q = MODE_KANJI;
					esc_len = 0;
					return;
				end else if (b == iso2j_pkg::CH_LPAREN) begin
					esc_bytes[2] = b;
					esc_len = 3;
					return;
				end else begin
					abort_escape(MODE_BINARY);
				end
			end
			3: begin
				if (b == CH_AT || b == CH_B || b == CH_D) begin
					mode_q = MODE_KANJI;
					esc_len = 0;
					return;
				end
				abort_escape(MODE_BINARY);
			end
			default: ;
		endcase

		// A held lead byte takes the next byte as its second half, whatever it is.
		if (lead_held) begin
			lead_held = 1'b0;
			emit_char({lead_q, b}, 1'b1);
		end else if (b == iso2j_pkg::BYTE_ESC) begin
			esc_bytes[0] = b;
			esc_len = 1;
		end else if (b == iso2j_pkg::BYTE_SO) begin
			mode_q = MODE_KANA8;
		end else if (b == iso2j_pkg::BYTE_SI) begin
			mode_q = MODE_ASCII;
		end else if (b < iso2j_pkg::BYTE_SPACE) begin
			mode_q = MODE_BINARY;
			emit_char({8'h00, b}, 1'b0);
		end else if (b < iso2j_pkg::KANA7_LIMIT && mode_q == MODE_KANA7) begin
			emit_char(halfwidth_map(b + HIGH_BIT), 1'b0);
		end else if (b == iso2j_pkg::BYTE_DEL) begin
			mode_q = MODE_BINARY;
			emit_char({8'h00, b}, 1'b0);
		end else if (b < iso2j_pkg::BYTE_DEL) begin
			if (mode_q == MODE_KANJI) begin
				lead_q = b;
				lead_held = 1'b1;
			end else begin
				emit_char(halfwidth_map(b), 1'b0);
			end
		end else if (b >= iso2j_pkg::KANA_FIRST && b <= iso2j_pkg::KANA_LAST &&
				mode_q == MODE_KANA8) begin
			emit_char(halfwidth_map(b), 1'b0);
		end else begin
			mode_q = MODE_BINARY;
			emit_char(halfwidth_map(b), 1'b0);
		end
	endfunction

	function automatic void predict_item(input logic [7:0] b, input logic eot);
		step_chars.delete();
		if (b != NO_BYTE) begin
			decode_text_byte(b);
		end
		if (eot) begin
			if (esc_len == 1 || esc_len == 3) begin
				abort_escape(MODE_BINARY);
			end else if (esc_len == 2) begin
				abort_escape(esc_bytes[1] == iso2j_pkg::CH_LPAREN ? MODE_ASCII : MODE_BINARY);
			end
			if (lead_held) begin
				lead_held = 1'b0;
				emit_char(halfwidth_map(lead_q), 1'b0);
			end
			lead_q = 8'h00;
			mode_q = MODE_ASCII;
		end
		if (step_chars.size() > 0) begin
			step_chars[step_chars.size()-1].last = 1'b1;
		end
	endfunction

	always @(posedge clk) begin : monitor
		char_result_t want;
		logic         moved;
		moved = 1'b0;
		if (arst_n) begin
			if (push && !full) begin
				moved = 1'b1;
				predict_item(data_byte, end_of_text);
				if (row_typed) begin
					awaited_chars.push_back('{row_code, 1'b0, 1'b1});
				end else begin
					foreach (step_chars[k]) begin
						awaited_chars.push_back(step_chars[k]);
					end
				end
			end
			if (pop && !empty) begin
				moved = 1'b1;
				if (awaited_chars.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("unexpected char: code %h two %b last %b",
							char_code, two_byte, run_last);
					end
				end else begin
					want = awaited_chars.pop_front();
					if (want.code !== char_code || want.two !== two_byte ||
							want.last !== run_last) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("char mismatch: expected %h/%b/%b, got %h/%b/%b",
								want.code, want.two, want.last,
								char_code, two_byte, run_last);
						end
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Entered at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_byte(input logic [7:0] b, input logic eot, input logic typed,
			input logic [15:0] code);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		end_of_text <= eot;
		row_typed <= typed;
		row_code <= code;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic send_text(input logic [7:0] b);
		send_byte(b, $urandom_range(0, 39) == 0, 1'b0, 16'h0000);
		items_sent++;
	endtask

	task automatic send_escape(input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3);
		send_text(iso2j_pkg::BYTE_ESC);
		send_text(b1);
		if (b2 != NO_BYTE) begin
			send_text(b2);
		end
		if (b3 != NO_BYTE) begin
			send_text(b3);
		end
	endtask

	function automatic logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12) begin
			return 8'($urandom_range(iso2j_pkg::BYTE_SPACE, iso2j_pkg::BYTE_TILDE));
		end else if (r < 15) begin
			return 8'($urandom_range(iso2j_pkg::KANA_FIRST, iso2j_pkg::KANA_LAST));
		end else if (r < 17) begin
			return 8'($urandom_range(1, iso2j_pkg::BYTE_SPACE - 1));
		end
		return 8'($urandom_range(1, 255));
	endfunction

	initial begin : receiver
		int stall;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, max_stall);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			@(negedge clk);
		end
	end

	initial begin : sender
		int pick;
		int next_reshape;
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = iso2j_pkg::BYTE_SPACE;
		end_of_text = 1'b0;
		row_typed = 1'b0;
		row_code = 16'h0000;
		mode_q = MODE_ASCII;
		esc_bytes = '{8'h00, 8'h00, 8'h00};
		esc_len = 0;
		lead_q = 8'h00;
		lead_held = 1'b0;
		items_sent = 0;
		mismatches = 0;
		idle_cycles = 0;
		next_reshape = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			send_byte(directed_rows[i].b, directed_rows[i].eot, directed_rows[i].typed,
				directed_rows[i].code);
			items_sent++;
		end

		while (items_sent < ITEM_TARGET) begin
			// Now and then one side runs without any idle cycles for a stretch.
			if (items_sent >= next_reshape) begin
				max_gap = ($urandom_range(0, 3) == 0) ? 0 : 5;
				max_stall = ($urandom_range(0, 3) == 0) ? 0 : 5;
				next_reshape = items_sent + 50;
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				case ($urandom_range(0, 9))
					0: send_escape(iso2j_pkg::CH_LPAREN, CH_B, NO_BYTE);
					1: send_escape(iso2j_pkg::CH_LPAREN, CH_I, NO_BYTE);
					2: send_escape(iso2j_pkg::CH_LPAREN, CH_J, NO_BYTE);
					3: send_escape(iso2j_pkg::CH_DOLLAR, CH_AT, NO_BYTE);
					4: send_escape(iso2j_pkg::CH_DOLLAR, CH_B, NO_BYTE);
					5: send_escape(iso2j_pkg::CH_DOLLAR, iso2j_pkg::CH_LPAREN, CH_AT);
					6: send_escape(iso2j_pkg::CH_DOLLAR, iso2j_pkg::CH_LPAREN, CH_B);
					7: send_escape(iso2j_pkg::CH_DOLLAR, iso2j_pkg::CH_LPAREN, CH_D);
					8: send_escape(CH_K, NO_BYTE, NO_BYTE);
					default: send_escape(CH_H, NO_BYTE, NO_BYTE);
				endcase
				repeat ($urandom_range(1, 8)) send_text(pick_text_byte());
			end else if (pick < 55) begin
				case ($urandom_range(0, 3))
					0: send_escape(8'($urandom_range(1, 255)), NO_BYTE, NO_BYTE);
					1: send_escape(iso2j_pkg::CH_LPAREN, 8'($urandom_range(1, 255)), NO_BYTE);
					2: send_escape(iso2j_pkg::CH_DOLLAR, 8'($urandom_range(1, 255)), NO_BYTE);
					default: send_escape(iso2j_pkg::CH_DOLLAR, iso2j_pkg::CH_LPAREN,
						8'($urandom_range(1, 255)));
				endcase
				repeat ($urandom_range(1, 4)) send_text(pick_text_byte());
			end else if (pick < 65) begin
				send_text(iso2j_pkg::BYTE_SO);
				repeat ($urandom_range(1, 5)) begin
					send_text(($urandom_range(0, 4) == 0) ? pick_text_byte() :
						8'($urandom_range(iso2j_pkg::KANA_FIRST - 1, iso2j_pkg::KANA_LAST)));
				end
				if ($urandom_range(0, 1) == 1) begin
					send_text(iso2j_pkg::BYTE_SI);
				end
			end else begin
				repeat ($urandom_range(1, 4)) send_text(8'($urandom_range(1, 255)));
			end
		end
		push <= 1'b0;

		while (awaited_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
